/* rtl/semi_lagrangian_advection_assert.svh */
// ---------------------------------------------------------------------------
// semi_lagrangian_advection_assert
// assertion macros shared by the advection rtl
// ---------------------------------------------------------------------------
`ifndef SEMI_LAGRANGIAN_ADVECTION_ASSERT_SVH
`define SEMI_LAGRANGIAN_ADVECTION_ASSERT_SVH

// implication checked every clock outside reset
`define SLA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define SLA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/sla_pkg.sv */
// ---------------------------------------------------------------------------
// sla_pkg
// shared types and constants of the advection block
// ---------------------------------------------------------------------------
package sla_pkg;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [15:0] STEP_SCALE_RESET = 16'd1638;

  typedef struct packed {
    logic               opcode;
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [15:0] cell_value;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               occupied;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         out_col;
    logic [6:0]         out_row;
    logic signed [15:0] advected_value;
  } out_item_t;

  // traced job handed from front to back
  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
    logic       occupied;
    logic [6:0] i0;
    logic [6:0] j0;
    logic [7:0] s1;
    logic [7:0] t1;
  } job_t;

endpackage

/* rtl/sla_front.sv */
// ---------------------------------------------------------------------------
// sla_front
// trace-back front: displacement multiply, clamp, split into index and weight
// ---------------------------------------------------------------------------
module sla_front #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sla_pkg::in_item_t in_item,
  input  logic [15:0]      step_scale,
  output logic             job_valid,
  output sla_pkg::job_t    job
);
  localparam int PW = $clog2((GRID_W > GRID_H ? GRID_W : GRID_H) * 256 + 129) + 1;
  localparam logic signed [34:0] XMAX = 35'(GRID_W * 256 + 128);
  localparam logic signed [34:0] YMAX = 35'(GRID_H * 256 + 128);

  // stage 1: products
  logic             s1_valid;
  logic [6:0]       s1_col, s1_row;
  logic             s1_occ;
  logic signed [32:0] prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && (in_item.opcode == sla_pkg::OP_COMPUTE);
    end
    s1_col <= in_item.col;
    s1_row <= in_item.row;
    s1_occ <= in_item.occupied;
    prod_x <= $signed({1'b0, step_scale}) * in_item.vel_x;
    prod_y <= $signed({1'b0, step_scale}) * in_item.vel_y;
  end

  // stage 2: arithmetic shift is floor division by 256
  logic signed [34:0] px, py, cx, cy;
  always_comb begin
    px = $signed({20'd0, s1_col, 8'd0}) - 35'(prod_x >>> 8);
    py = $signed({20'd0, s1_row, 8'd0}) - 35'(prod_y >>> 8);
    cx = (px < 35'sd128) ? 35'sd128 : ((px > XMAX) ? XMAX : px);
    cy = (py < 35'sd128) ? 35'sd128 : ((py > YMAX) ? YMAX : py);
  end

  logic [PW-1:0] cxn, cyn;
  assign cxn = cx[PW-1:0];
  assign cyn = cy[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= s1_valid;
    end
    job.col      <= s1_col;
    job.row      <= s1_row;
    job.occupied <= s1_occ;
    job.i0       <= 7'(cxn >> 8);
    job.j0       <= 7'(cyn >> 8);
    job.s1       <= cxn[7:0];
    job.t1       <= cyn[7:0];
  end
endmodule

/* rtl/sla_queue.sv */
// ---------------------------------------------------------------------------
// sla_queue
// short fifo between the trace front and the interpolation back
// ---------------------------------------------------------------------------
module sla_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sla_pkg::job_t push_job,
  input  logic          pop,
  output logic          not_empty,
  output sla_pkg::job_t head
);
  localparam int AW = $clog2(DEPTH);
  sla_pkg::job_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) slots[wr_ptr] <= push_job;
  end

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
endmodule

/* rtl/sla_back.sv */
// ---------------------------------------------------------------------------
// sla_back
// banked source grid with four parity banks and the bilinear blend pipeline
// ---------------------------------------------------------------------------
`include "semi_lagrangian_advection_assert.svh"
module sla_back #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [6:0]        wr_col,
  input  logic [6:0]        wr_row,
  input  logic [15:0]       wr_data,
  input  logic              job_valid,
  input  sla_pkg::job_t     job,
  output logic              res_valid,
  output sla_pkg::out_item_t res
);
  localparam int BW    = (GRID_W + 3) / 2;
  localparam int BH    = (GRID_H + 3) / 2;
  localparam int BDEP  = BW * BH;
  localparam int BAW   = $clog2(BDEP);

  // bank index is {row parity, col parity}
  logic [15:0] bank0 [BDEP];
  logic [15:0] bank1 [BDEP];
  logic [15:0] bank2 [BDEP];
  logic [15:0] bank3 [BDEP];

  logic [BAW-1:0] wr_addr;
  assign wr_addr = BAW'(32'(wr_row >> 1) * BW + 32'(wr_col >> 1));

  always_ff @(posedge clk) begin
    if (wr_en && !wr_col[0] && !wr_row[0]) bank0[wr_addr] <= wr_data;
    if (wr_en &&  wr_col[0] && !wr_row[0]) bank1[wr_addr] <= wr_data;
    if (wr_en && !wr_col[0] &&  wr_row[0]) bank2[wr_addr] <= wr_data;
    if (wr_en &&  wr_col[0] &&  wr_row[0]) bank3[wr_addr] <= wr_data;
  end

  // each bank holds the one corner whose parities match it
  logic [6:0] ce, co, re, ro;
  always_comb begin
    ce = job.i0[0] ? job.i0 + 7'd1 : job.i0;
    co = job.i0[0] ? job.i0 : job.i0 + 7'd1;
    re = job.j0[0] ? job.j0 + 7'd1 : job.j0;
    ro = job.j0[0] ? job.j0 : job.j0 + 7'd1;
  end
  logic [BAW-1:0] a0, a1, a2, a3;
  assign a0 = BAW'(32'(re >> 1) * BW + 32'(ce >> 1));
  assign a1 = BAW'(32'(re >> 1) * BW + 32'(co >> 1));
  assign a2 = BAW'(32'(ro >> 1) * BW + 32'(ce >> 1));
  assign a3 = BAW'(32'(ro >> 1) * BW + 32'(co >> 1));

  logic        r_valid;
  sla_pkg::job_t r_job;
  logic [15:0] d0, d1, d2, d3;
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= job_valid;
    end
    r_job <= job;
    d0 <= bank0[a0];
    d1 <= bank1[a1];
    d2 <= bank2[a2];
    d3 <= bank3[a3];
  end

  // unswap banks into corners (i0,j0) (i0+1,j0) (i0,j0+1) (i0+1,j0+1)
  logic signed [15:0] v00, v10, v01, v11;
  always_comb begin
    case ({r_job.j0[0], r_job.i0[0]})
      2'b00:   begin v00 = d0; v10 = d1; v01 = d2; v11 = d3; end
      2'b01:   begin v00 = d1; v10 = d0; v01 = d3; v11 = d2; end
      2'b10:   begin v00 = d2; v10 = d3; v01 = d0; v11 = d1; end
      default: begin v00 = d3; v10 = d2; v01 = d1; v11 = d0; end
    endcase
  end

  logic signed [9:0] t0, t1;
  assign t1 = $signed({2'b0, r_job.t1});
  assign t0 = 10'sd256 - t1;

  // vertical blend
  logic        v_valid;
  sla_pkg::job_t v_job;
  logic signed [15:0] p, q;
  logic signed [26:0] sp, sq;
  always_comb begin
    sp = t0 * v00 + t1 * v01;
    sq = t0 * v10 + t1 * v11;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else begin
      v_valid <= r_valid;
    end
    v_job <= r_job;
    p <= 16'(sp >>> 8);
    q <= 16'(sq >>> 8);
  end

  // horizontal blend
  logic signed [9:0]  s0, s1;
  logic signed [26:0] sv;
  assign s1 = $signed({2'b0, v_job.s1});
  assign s0 = 10'sd256 - s1;
  assign sv = s0 * p + s1 * q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= v_valid;
    end
    res.out_col        <= v_job.col;
    res.out_row        <= v_job.row;
    res.advected_value <= v_job.occupied ? 16'sd0 : 16'(sv >>> 8);
  end

  `SLA_ASSERT_NXT(a_read_to_blend, r_valid, v_valid)
  `SLA_ASSERT_NXT(a_blend_to_out, v_valid, res_valid)
  `SLA_ASSERT_IMP(a_weight_sum, r_valid, (t0 + t1) == 10'sd256)
endmodule

/* rtl/semi_lagrangian_advection.sv */
// ---------------------------------------------------------------------------
// semi_lagrangian_advection
// semi-lagrangian advection of a padded scalar grid, signed q8.8
// ---------------------------------------------------------------------------
// busy is always low: one item transfer every cycle, loads and computes
// mixed freely. a compute item raises done after passing its pipeline
// (2 trace stages with the first loaded at the transfer edge, 1 queue slot,
// registered grid read, 2 blend stages); a load gives none. a load passes
// ld_d1, ld_d2, ld_d3 and reaches the grid on the edge where a compute
// taking that same slot would read it, so every compute sees exactly the
// loads transferred before it and none after. the grid sits in four banks
// split by index parity so all four bilinear corners come out of one read.
// the receiver cannot stall, so a result shows on out_item for one cycle
// with done high. grid cells are undefined until loaded; step_scale resets
// to 1638 (about 6.4 in q8.8).
`include "semi_lagrangian_advection_assert.svh"
module semi_lagrangian_advection #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sla_pkg::in_item_t  in_item,
  output logic               done,
  output sla_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  logic [15:0] step_scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= sla_pkg::STEP_SCALE_RESET;
    end else if (cfg_we) begin
      step_scale <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // loads outside the padded grid are dropped
  logic load_ok;
  assign load_ok = start && (in_item.opcode == sla_pkg::OP_LOAD)
                 && (32'(in_item.col) < GRID_W + 2) && (32'(in_item.row) < GRID_H + 2);

  // load delay line {col, row, value}, matched to the compute read point
  logic        ld_ok_d1, ld_ok_d2, ld_ok_d3;
  logic [29:0] ld_d1, ld_d2, ld_d3;
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_ok_d1 <= 1'b0;
      ld_ok_d2 <= 1'b0;
      ld_ok_d3 <= 1'b0;
    end else begin
      ld_ok_d1 <= load_ok;
      ld_ok_d2 <= ld_ok_d1;
      ld_ok_d3 <= ld_ok_d2;
    end
    ld_d1 <= {in_item.col, in_item.row, in_item.cell_value};
    ld_d2 <= ld_d1;
    ld_d3 <= ld_d2;
  end

  logic          f_valid;
  sla_pkg::job_t f_job;
  sla_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .clk, .rst, .in_valid(start), .in_item, .step_scale,
    .job_valid(f_valid), .job(f_job)
  );

  // back always drains one per cycle, queue just decouples timing
  logic          q_ne;
  sla_pkg::job_t q_head;
  sla_queue #(.DEPTH(4)) u_queue (
    .clk, .rst, .push(f_valid), .push_job(f_job),
    .pop(q_ne), .not_empty(q_ne), .head(q_head)
  );

  sla_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk, .rst,
    .wr_en(ld_ok_d3), .wr_col(ld_d3[29:23]), .wr_row(ld_d3[22:16]),
    .wr_data(ld_d3[15:0]),
    .job_valid(q_ne), .job(q_head),
    .res_valid(done), .res(out_item)
  );

  `SLA_ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `SLA_ASSERT_NXT(a_load_no_trace, start && in_item.opcode == sla_pkg::OP_LOAD, !u_front.s1_valid)
  `SLA_ASSERT_NXT(a_compute_traces, start && in_item.opcode == sla_pkg::OP_COMPUTE, u_front.s1_valid)
endmodule
